>>> sv/icymd_pkg.sv
// Shared types and constants for the interleaved audio/metadata deframer.
// No dependencies; imported by icymd_store and icy_metadata_deframer_core.
package icymd_pkg;

  // Metadata store geometry
  localparam int META_BYTES_MAX = 4096;
  localparam int META_ADDR_W    = $clog2(META_BYTES_MAX);
  localparam int META_LEN_W     = META_ADDR_W + 1;

  // Metadata length byte counts units of 16 bytes
  localparam int META_UNIT_SHIFT = 4;

  // Interval register
  localparam int INTERVAL_W = 31;
  localparam logic [INTERVAL_W-1:0] INTERVAL_LIMIT = INTERVAL_W'(1 << 30);

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_META  = 2'd2
  } byte_kind_e;

  // Write request into the metadata store
  typedef struct packed {
    logic                   en;
    logic [META_ADDR_W-1:0] addr;
    logic [7:0]             data;
  } store_wr_t;

endpackage

>>> sv/icymd_store.sv
// Metadata text store: one write port, one read port with registered data.
// Depends on icymd_pkg for the address width and the write request struct.
module icymd_store (
  input  logic                            clk_i,
  input  icymd_pkg::store_wr_t            wr_i,
  input  logic [icymd_pkg::META_ADDR_W-1:0] rd_addr_i,
  output logic [7:0]                      rd_data_o
);
  import icymd_pkg::*;

  logic [7:0] mem_q [META_BYTES_MAX];
  logic [7:0] rd_data_q;

  // Write and read in one clocked block; read data appears the next cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/icy_metadata_deframer_core.sv
// Channel   Handshake             Payload
// in        in_valid_i/in_stall_o  in_byte_i
// out       out_valid_o/out_stall_i out_byte_o, byte_kind_o, block_end_o, meta_changed_o
// cfg       cfg_we_i              cfg_wdata_i (metadata interval)
//
// One byte per cycle while in_stall_o is low; each request gives one result, registered in the cycle after it is taken.
// The store read for the next metadata byte is issued when the current one is taken, so the
// compare against stored text uses registered read data with no extra wait.
// Reset clears all control state; the metadata store holds no reset value.
// in_stall_o rises only while a result is held and out_stall_i is high.
//
// Top level of the deframer: phase sequencer, text compare, output register.
// Depends on icymd_pkg and icymd_store.
module icy_metadata_deframer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icymd_pkg::INTERVAL_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic [1:0]                        byte_kind_o,
  output logic                              block_end_o,
  output logic                              meta_changed_o
);
  import icymd_pkg::*;

  logic                   accept;

  logic [INTERVAL_W-1:0]  interval_q, interval_d;
  logic [INTERVAL_W-1:0]  audio_cnt_q, audio_cnt_d, audio_cnt_inc;
  phase_e                 phase_q, phase_d;
  logic [META_ADDR_W-1:0] meta_rem_q, meta_rem_d;
  logic [META_ADDR_W-1:0] meta_idx_q, meta_idx_d;
  logic [META_LEN_W-1:0]  stored_len_q, stored_len_d;
  logic [META_LEN_W-1:0]  new_len_q, new_len_d;
  logic                   text_ended_q, text_ended_d;
  logic                   mismatch_q, mismatch_d;
  logic                   have_stored_q, have_stored_d;

  store_wr_t              store_wr;
  logic [7:0]             store_rd_data;

  byte_kind_e             kind;
  logic                   block_end, changed;

  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  byte_kind_e             out_kind_q;
  logic                   out_end_q, out_changed_q;

  // Take a request when the output register is empty or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Phase sequencer, text compare and store write
  always_comb begin
    interval_d    = interval_q;
    audio_cnt_d   = audio_cnt_q;
    phase_d       = phase_q;
    meta_rem_d    = meta_rem_q;
    meta_idx_d    = meta_idx_q;
    stored_len_d  = stored_len_q;
    new_len_d     = new_len_q;
    text_ended_d  = text_ended_q;
    mismatch_d    = mismatch_q;
    have_stored_d = have_stored_q;
    audio_cnt_inc = audio_cnt_q + INTERVAL_W'(1);
    kind          = KIND_AUDIO;
    block_end     = 1'b0;
    changed       = 1'b0;
    store_wr.en   = 1'b0;
    store_wr.addr = meta_idx_q;
    store_wr.data = in_byte_i;

    if (cfg_we_i) begin
      // Out-of-range interval means pass-through
      interval_d    = (cfg_wdata_i > INTERVAL_LIMIT) ? '0 : cfg_wdata_i;
      audio_cnt_d   = '0;
      phase_d       = PH_AUDIO;
      have_stored_d = 1'b0;
    end else if (accept && (interval_q != '0)) begin
      case (phase_q)
        PH_AUDIO: begin
          if (audio_cnt_inc >= interval_q) begin
            audio_cnt_d = '0;
            phase_d     = PH_LEN;
          end else begin
            audio_cnt_d = audio_cnt_inc;
          end
        end
        PH_LEN: begin
          kind = KIND_LEN;
          if (in_byte_i == 8'd0) begin
            block_end = 1'b1;
            phase_d   = PH_AUDIO;
          end else begin
            meta_rem_d   = META_ADDR_W'({in_byte_i, {META_UNIT_SHIFT{1'b0}}});
            meta_idx_d   = '0;
            new_len_d    = '0;
            text_ended_d = 1'b0;
            mismatch_d   = 1'b0;
            phase_d      = PH_META;
          end
        end
        PH_META: begin
          kind = KIND_META;
          // Text runs to the first zero byte
          if (!text_ended_q) begin
            if (in_byte_i == 8'd0) begin
              text_ended_d = 1'b1;
            end else begin
              if (({1'b0, meta_idx_q} >= stored_len_q) || (store_rd_data != in_byte_i)) begin
                mismatch_d = 1'b1;
              end
              store_wr.en = 1'b1;
              new_len_d   = new_len_q + META_LEN_W'(1);
            end
          end
          meta_idx_d = meta_idx_q + META_ADDR_W'(1);
          meta_rem_d = (meta_rem_q != '0) ? meta_rem_q - META_ADDR_W'(1) : '0;
          // Last byte of the block: decide on change
          if (meta_rem_d == '0) begin
            block_end = 1'b1;
            if (!have_stored_q || mismatch_d || (new_len_d != stored_len_q)) begin
              changed       = 1'b1;
              stored_len_d  = new_len_d;
              have_stored_d = 1'b1;
            end
            phase_d = PH_AUDIO;
          end
        end
        default: begin
          phase_d = PH_AUDIO;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= '0;
      audio_cnt_q   <= '0;
      phase_q       <= PH_AUDIO;
      meta_rem_q    <= '0;
      meta_idx_q    <= '0;
      stored_len_q  <= '0;
      new_len_q     <= '0;
      text_ended_q  <= 1'b0;
      mismatch_q    <= 1'b0;
      have_stored_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      interval_q    <= interval_d;
      audio_cnt_q   <= audio_cnt_d;
      phase_q       <= phase_d;
      meta_rem_q    <= meta_rem_d;
      meta_idx_q    <= meta_idx_d;
      stored_len_q  <= stored_len_d;
      new_len_q     <= new_len_d;
      text_ended_q  <= text_ended_d;
      mismatch_q    <= mismatch_d;
      have_stored_q <= have_stored_d;
      out_valid_q   <= accept || (out_valid_q && out_stall_i);
    end
  end

  // Result payload, loaded on each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q    <= in_byte_i;
      out_kind_q    <= kind;
      out_end_q     <= block_end;
      out_changed_q <= changed;
    end
  end

  // Store read is addressed with the next index, ready when that byte arrives
  icymd_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_addr_i (meta_idx_d),
    .rd_data_o (store_rd_data)
  );

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_kind_o    = out_kind_q;
  assign block_end_o    = out_end_q;
  assign meta_changed_o = out_changed_q;

  // Checks
  a_changed_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && meta_changed_o |-> block_end_o)
    else $error("meta_changed without block_end");

  a_end_not_audio : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |-> (byte_kind_o == KIND_LEN) || (byte_kind_o == KIND_META))
    else $error("block_end on an audio byte");

  a_meta_rem_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_META) |-> (meta_rem_q != '0))
    else $error("metadata phase with nothing remaining");

  a_passthru_audio : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (interval_q == '0) |-> (phase_q == PH_AUDIO))
    else $error("deframing phase left audio while disabled");

  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule
